/* rtl/odh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odh_pkg - shared definitions of the orbit density histogram unit
// Geometry, field codes, register indexes and the structs that pass
// between the bin mapper, the counter bank and the result queue.
// ----------------------------------------------------------------------------
package odh_pkg;

  // histogram geometry
  localparam int COLUMNS = 256;
  localparam int ROWS    = 256;
  localparam int NBINS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(NBINS);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS);

  // field widths
  localparam int COORD_W = 32;
  localparam int SCALE_W = 32;
  localparam int LEN_W   = 16;
  localparam int RBIN_W  = 16;
  localparam int CNT_W   = 32;
  localparam int STAT_W  = 2;
  localparam int BIN_Q_W = 20;   // bits of the product above the Q44 point

  // stream widths
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 104;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int OUT_W      = $clog2(FIFO_DEPTH + 1);

  // operation codes
  localparam logic OP_DEPOSIT = 1'b0;
  localparam logic OP_READ    = 1'b1;

  // status codes
  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_SHORT   = 2'd1;
  localparam logic [STAT_W-1:0] ST_OUTSIDE = 2'd2;

  // histogram select
  localparam logic [1:0] COLOR_BLUE  = 2'd0;
  localparam logic [1:0] COLOR_GREEN = 2'd1;
  localparam logic [1:0] COLOR_RED   = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_RE_ORIGIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IM_ORIGIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RE_SCALE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IM_SCALE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_BELOW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_BELOW  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_BELOW = 3'd6;

  // configuration reset values
  localparam logic [COORD_W-1:0] RST_ORIGIN = 32'hE000_0000;  // -2.0
  localparam logic [SCALE_W-1:0] RST_SCALE  = 32'h0040_0000;  // 64.0
  localparam logic [LEN_W-1:0]   RST_IGNORE = 16'd0;
  localparam logic [LEN_W-1:0]   RST_BLUE   = 16'd100;
  localparam logic [LEN_W-1:0]   RST_GREEN  = 16'd1000;

  typedef struct packed {
    logic [COORD_W-1:0] re_origin;
    logic [COORD_W-1:0] im_origin;
    logic [SCALE_W-1:0] re_scale;
    logic [SCALE_W-1:0] im_scale;
    logic [LEN_W-1:0]   ignore_below;
    logic [LEN_W-1:0]   blue_below;
    logic [LEN_W-1:0]   green_below;
  } cfg_t;

  // one mapped item handed to the counter bank
  typedef struct packed {
    logic              valid;
    logic              op;
    logic [STAT_W-1:0] status;
    logic [1:0]        color;
    logic [ADDR_W-1:0] addr0;
    logic [ADDR_W-1:0] addr1;
  } job_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  red;
    logic [CNT_W-1:0]  green;
    logic [CNT_W-1:0]  blue;
  } result_t;

endpackage

/* rtl/orbit_density_histogram_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orbit_density_histogram_unit - three colour trajectory point histograms
// Bins orbit points into blue, green or red counters by trajectory length
// and returns the three counts of one bin on a read.
//
//   channel  direction  beat fields
//   s_*      in         tuser: op; tdata: point_re, point_im, orbit_length,
//                       read_bin
//   m_*      out        tdata: status, red_count, green_count, blue_count
//   cfg_*    in         register write: index, data
//
// A deposit makes two read-modify-write passes, bin and row
// mirror, through the single access slot of the counter bank; a read
// makes one. After reset the counters are cleared, during which
// s_tready is low; configuration writes are taken at any time.
// Up to 8 items may be in flight or queued; with 8 outstanding, s_tready
// drops until m_tready takes a beat.
// ----------------------------------------------------------------------------
module orbit_density_histogram_unit
  import odh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // point_re, point_im, orbit_length, read_bin
  input  logic                  s_tuser,   // op
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // status, red_count, green_count, blue_count
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]           cfg_wdata
);

  // configuration registers
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.re_origin    <= RST_ORIGIN;
      cfg.im_origin    <= RST_ORIGIN;
      cfg.re_scale     <= RST_SCALE;
      cfg.im_scale     <= RST_SCALE;
      cfg.ignore_below <= RST_IGNORE;
      cfg.blue_below   <= RST_BLUE;
      cfg.green_below  <= RST_GREEN;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RE_ORIGIN:    cfg.re_origin    <= cfg_wdata;
        REG_IM_ORIGIN:    cfg.im_origin    <= cfg_wdata;
        REG_RE_SCALE:     cfg.re_scale     <= cfg_wdata;
        REG_IM_SCALE:     cfg.im_scale     <= cfg_wdata;
        REG_IGNORE_BELOW: cfg.ignore_below <= cfg_wdata[LEN_W-1:0];
        REG_BLUE_BELOW:   cfg.blue_below   <= cfg_wdata[LEN_W-1:0];
        REG_GREEN_BELOW:  cfg.green_below  <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input acceptance: gap after a deposit, credit for the result queue
  logic             clearing;
  logic             gap;
  logic [OUT_W-1:0] outstanding;
  logic             in_accept;
  logic             out_pop;

  assign s_tready  = !clearing && !gap && (outstanding != OUT_W'(FIFO_DEPTH));
  assign in_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap         <= 1'b0;
      outstanding <= '0;
    end else begin
      gap <= in_accept && s_tuser == OP_DEPOSIT;
      if (in_accept && !out_pop) begin
        outstanding <= outstanding + OUT_W'(1);
      end else if (!in_accept && out_pop) begin
        outstanding <= outstanding - OUT_W'(1);
      end
    end
  end

  // bin mapping
  job_t job;

  odh_bin_map u_bin_map (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_accept),
    .in_op        (s_tuser),
    .point_re     (s_tdata[31:0]),
    .point_im     (s_tdata[63:32]),
    .orbit_length (s_tdata[79:64]),
    .read_bin     (s_tdata[95:80]),
    .cfg          (cfg),
    .job          (job)
  );

  // counter bank
  logic    res_valid;
  result_t res;

  odh_bank u_bank (
    .clk       (clk),
    .rst       (rst),
    .job       (job),
    .clearing  (clearing),
    .res_valid (res_valid),
    .res       (res)
  );

  // result queue and output beat
  result_t head;

  assign out_pop = m_tvalid && m_tready;

  odh_result_fifo u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .din       (res),
    .pop       (m_tready),
    .not_empty (m_tvalid),
    .dout      (head)
  );

  assign m_tdata = {6'b0, head.blue, head.green, head.red, head.status};

  // credit count bounded by the queue depth
  a_credit_range: assert property (@(posedge clk) disable iff (rst)
    outstanding <= OUT_W'(FIFO_DEPTH))
    else $error("outstanding count out of range");

  // a result on the output belongs to an outstanding item
  a_result_owned: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> outstanding != '0)
    else $error("result without outstanding item");

  // a deposit leaves the next cycle to its mirror increment
  a_deposit_gap: assert property (@(posedge clk) disable iff (rst)
    (in_accept && s_tuser == OP_DEPOSIT) |=> !s_tready)
    else $error("beat accepted in mirror slot");

endmodule

/* rtl/odh_bin_map.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odh_bin_map - maps an accepted beat to histogram addresses
// Three registered stages: window offset and length class, the two
// fixed-point scale multiplies, then window test and reversed addresses.
// ----------------------------------------------------------------------------
module odh_bin_map
  import odh_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_op,
  input  logic [COORD_W-1:0] point_re,
  input  logic [COORD_W-1:0] point_im,
  input  logic [LEN_W-1:0]   orbit_length,
  input  logic [RBIN_W-1:0]  read_bin,
  input  cfg_t               cfg,
  output job_t               job
);

  // stage 1: offsets from the window origin and length class
  logic [COORD_W:0] diff_re;
  logic [COORD_W:0] diff_im;
  logic [1:0]       color_sel;

  assign diff_re = {point_re[COORD_W-1], point_re} - {cfg.re_origin[COORD_W-1], cfg.re_origin};
  assign diff_im = {point_im[COORD_W-1], point_im} - {cfg.im_origin[COORD_W-1], cfg.im_origin};

  always_comb begin
    if (orbit_length < cfg.blue_below) begin
      color_sel = COLOR_BLUE;
    end else if (orbit_length < cfg.green_below) begin
      color_sel = COLOR_GREEN;
    end else begin
      color_sel = COLOR_RED;
    end
  end

  logic               s1_valid;
  logic               s1_op;
  logic               s1_short;
  logic [1:0]         s1_color;
  logic               s1_re_neg;
  logic               s1_im_neg;
  logic [COORD_W-1:0] s1_re_mag;
  logic [COORD_W-1:0] s1_im_mag;
  logic [RBIN_W-1:0]  s1_read_bin;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_op       <= in_op;
    s1_short    <= orbit_length < cfg.ignore_below;
    s1_color    <= color_sel;
    s1_re_neg   <= diff_re[COORD_W];
    s1_im_neg   <= diff_im[COORD_W];
    s1_re_mag   <= diff_re[COORD_W-1:0];
    s1_im_mag   <= diff_im[COORD_W-1:0];
    s1_read_bin <= read_bin;
  end

  // stage 2: scale multiplies, keep the integer part from bit 44 up
  logic [2*COORD_W-1:0] prod_re;
  logic [2*COORD_W-1:0] prod_im;

  assign prod_re = (2*COORD_W)'(s1_re_mag) * (2*COORD_W)'(cfg.re_scale);
  assign prod_im = (2*COORD_W)'(s1_im_mag) * (2*COORD_W)'(cfg.im_scale);

  logic               s2_valid;
  logic               s2_op;
  logic               s2_short;
  logic [1:0]         s2_color;
  logic               s2_re_neg;
  logic               s2_im_neg;
  logic [BIN_Q_W-1:0] s2_col_q;
  logic [BIN_Q_W-1:0] s2_row_q;
  logic [RBIN_W-1:0]  s2_read_bin;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_op       <= s1_op;
    s2_short    <= s1_short;
    s2_color    <= s1_color;
    s2_re_neg   <= s1_re_neg;
    s2_im_neg   <= s1_im_neg;
    s2_col_q    <= prod_re[2*COORD_W-1 -: BIN_Q_W];
    s2_row_q    <= prod_im[2*COORD_W-1 -: BIN_Q_W];
    s2_read_bin <= s1_read_bin;
  end

  // stage 3: window test and reversed bin addresses
  logic              outside;
  logic              read_outside;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [ROW_W-1:0]  mrow;
  logic [ADDR_W-1:0] base;
  logic [STAT_W-1:0] status;

  assign outside = s2_re_neg || s2_im_neg
                || (s2_col_q >= BIN_Q_W'(COLUMNS)) || (s2_row_q >= BIN_Q_W'(ROWS));
  assign read_outside = 32'(s2_read_bin) >= 32'(NBINS);
  assign col  = s2_col_q[COL_W-1:0];
  assign row  = s2_row_q[ROW_W-1:0];
  assign mrow = ROW_W'(ROWS - 1) - row;
  assign base = ADDR_W'(NBINS - 1) - ADDR_W'(col) * ADDR_W'(ROWS);

  always_comb begin
    if (s2_op == OP_READ) begin
      status = read_outside ? ST_OUTSIDE : ST_DONE;
    end else if (s2_short) begin
      status = ST_SHORT;
    end else if (outside) begin
      status = ST_OUTSIDE;
    end else begin
      status = ST_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job.valid <= 1'b0;
    end else begin
      job.valid <= s2_valid;
    end
    job.op     <= s2_op;
    job.status <= status;
    job.color  <= s2_color;
    job.addr0  <= (s2_op == OP_READ) ? ADDR_W'(s2_read_bin) : base - ADDR_W'(row);
    job.addr1  <= base - ADDR_W'(mrow);
  end

endmodule

/* rtl/odh_bank.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odh_bank - histogram counter memory with read-modify-write
// One memory word holds the red, green and blue counts of a bin. One
// access slot a cycle: read in the issue cycle, saturating increment and
// write back in the next, with one-deep write forwarding.
// A clearing pass zeroes the memory after reset.
// ----------------------------------------------------------------------------
module odh_bank
  import odh_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  job_t    job,
  output logic    clearing,
  output logic    res_valid,
  output result_t res
);

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_INC  = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // clearing pass after reset
  logic              clr_active;
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == ADDR_W'(NBINS - 1)) begin
        clr_active <= 1'b0;
      end
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  assign clearing = clr_active;

  // issue slot: pending mirror increment first, then a new job
  logic              sec_valid;
  logic [ADDR_W-1:0] sec_addr;
  logic [1:0]        sec_color;
  logic              sec_load;
  logic              iss_valid;
  logic [1:0]        iss_kind;
  logic [1:0]        iss_color;
  logic [ADDR_W-1:0] iss_addr;
  logic [STAT_W-1:0] iss_status;
  logic              iss_last;

  always_comb begin
    iss_valid  = 1'b0;
    iss_kind   = KIND_NONE;
    iss_color  = sec_color;
    iss_addr   = sec_addr;
    iss_status = ST_DONE;
    iss_last   = 1'b1;
    sec_load   = 1'b0;
    if (sec_valid) begin
      iss_valid = 1'b1;
      iss_kind  = KIND_INC;
    end else if (job.valid) begin
      iss_valid  = 1'b1;
      iss_color  = job.color;
      iss_addr   = job.addr0;
      iss_status = job.status;
      if (job.status == ST_DONE && job.op == OP_DEPOSIT) begin
        iss_kind = KIND_INC;
        iss_last = 1'b0;
        sec_load = 1'b1;
      end else if (job.status == ST_DONE) begin
        iss_kind = KIND_READ;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sec_valid <= 1'b0;
    end else begin
      sec_valid <= sec_load;
    end
    if (sec_load) begin
      sec_addr  <= job.addr1;
      sec_color <= job.color;
    end
  end

  // write-back stage registers
  logic              b_valid;
  logic [1:0]        b_kind;
  logic [1:0]        b_color;
  logic [ADDR_W-1:0] b_addr;
  logic [STAT_W-1:0] b_status;
  logic              b_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= iss_valid;
    end
    b_kind   <= iss_kind;
    b_color  <= iss_color;
    b_addr   <= iss_addr;
    b_status <= iss_status;
    b_last   <= iss_last;
  end

  // forwarding of the word written in the previous cycle
  logic                 w_valid;
  logic [ADDR_W-1:0]    w_addr;
  logic [3*CNT_W-1:0]   w_word;
  logic [3*CNT_W-1:0]   rd_word;
  logic [3*CNT_W-1:0]   cur_word;
  logic [3*CNT_W-1:0]   new_word;
  logic [CNT_W-1:0]     cur_red;
  logic [CNT_W-1:0]     cur_green;
  logic [CNT_W-1:0]     cur_blue;
  logic [CNT_W-1:0]     cur_sel;
  logic [CNT_W-1:0]     inc_val;
  logic                 inc_we;

  assign cur_word  = (w_valid && w_addr == b_addr) ? w_word : rd_word;
  assign cur_red   = cur_word[2*CNT_W +: CNT_W];
  assign cur_green = cur_word[CNT_W +: CNT_W];
  assign cur_blue  = cur_word[0 +: CNT_W];

  // saturating increment of the selected count
  assign inc_val = (&cur_sel) ? cur_sel : cur_sel + CNT_W'(1);
  assign inc_we  = b_valid && b_kind == KIND_INC;

  always_comb begin
    case (b_color)
      COLOR_RED: begin
        cur_sel  = cur_red;
        new_word = {inc_val, cur_green, cur_blue};
      end
      COLOR_GREEN: begin
        cur_sel  = cur_green;
        new_word = {cur_red, inc_val, cur_blue};
      end
      default: begin
        cur_sel  = cur_blue;
        new_word = {cur_red, cur_green, inc_val};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= 1'b0;
    end else begin
      w_valid <= inc_we;
    end
    w_addr <= b_addr;
    w_word <= new_word;
  end

  // counter memory
  logic [3*CNT_W-1:0] mem [NBINS];
  logic [ADDR_W-1:0]  wr_addr;
  logic [3*CNT_W-1:0] wr_data;
  logic               we;

  assign wr_addr = clr_active ? clr_addr : b_addr;
  assign wr_data = clr_active ? '0 : new_word;
  assign we      = clr_active || inc_we;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_word <= mem[iss_addr];
  end

  // result of the last access of each item
  assign res_valid  = b_valid && b_last;
  assign res.status = b_status;
  assign res.red    = (b_kind == KIND_READ) ? cur_red : '0;
  assign res.green  = (b_kind == KIND_READ) ? cur_green : '0;
  assign res.blue   = (b_kind == KIND_READ) ? cur_blue : '0;

  // no job may arrive while the clearing pass runs
  a_no_job_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> !job.valid)
    else $error("job arrived during clearing pass");

  // a pending mirror increment owns the slot
  a_no_job_with_mirror: assert property (@(posedge clk) disable iff (rst)
    sec_valid |-> !job.valid)
    else $error("job collided with pending mirror increment");

  // a counter never wraps to zero
  a_no_wrap: assert property (@(posedge clk) disable iff (rst)
    (inc_we && !clr_active) |-> (inc_val != '0))
    else $error("counter wrapped");

endmodule

/* rtl/odh_result_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odh_result_fifo - small result queue in front of the output stream
// Register-based queue; the head entry drives the output beat directly.
// ----------------------------------------------------------------------------
module odh_result_fifo
  import odh_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t din,
  input  logic    pop,
  output logic    not_empty,
  output result_t dout
);

  result_t                entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr;
  logic [FIFO_PTR_W-1:0]  rd_ptr;
  logic [FIFO_PTR_W:0]    count;
  logic                   do_pop;

  assign not_empty = count != '0;
  assign do_pop    = pop && not_empty;
  assign dout      = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + (FIFO_PTR_W+1)'(1);
      end else if (!push && do_pop) begin
        count <= count - (FIFO_PTR_W+1)'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  // never pushed when full, unless a pop frees an entry in the same cycle
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != (FIFO_PTR_W+1)'(FIFO_DEPTH) || do_pop))
    else $error("result queue overflow");

  // fill level stays in range
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (FIFO_PTR_W+1)'(FIFO_DEPTH))
    else $error("result queue level out of range");

  // a pop moves the head by one
  a_pop_moves: assert property (@(posedge clk) disable iff (rst)
    do_pop |=> rd_ptr == $past(rd_ptr) + FIFO_PTR_W'(1))
    else $error("head pointer slip");

endmodule

/* tb/histogram_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_checker - result checker of the orbit density histogram unit
// Watches the register port and both streams. Keeps its own copy of the
// three colour count stores and of the window settings, works out the
// result of every accepted input beat, and compares each output beat
// field by field against the oldest outstanding result.
// ----------------------------------------------------------------------------
module histogram_checker
  import odh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // point_re, point_im, orbit_length, read_bin
  input  logic                  s_tuser,   // op
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,   // status, red_count, green_count, blue_count
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]           cfg_wdata,
  output int                    mismatches,
  output int                    outstanding,
  output int                    n_done,
  output int                    n_short,
  output int                    n_outside
);

  // input beat field offsets
  localparam int RE_LSB   = 0;
  localparam int IM_LSB   = COORD_W;
  localparam int LEN_LSB  = 2 * COORD_W;
  localparam int RBIN_LSB = 2 * COORD_W + LEN_W;

  // output beat field offsets
  localparam int RED_LSB   = STAT_W;
  localparam int GREEN_LSB = STAT_W + CNT_W;
  localparam int BLUE_LSB  = STAT_W + 2 * CNT_W;

  // counter stores, indexed by colour code; they start cleared
  bit [CNT_W-1:0] hist [3][NBINS];
  cfg_t           window;
  result_t        expected_counts [$];

  int bad_cnt   = 0;
  int done_cnt  = 0;
  int short_cnt = 0;
  int out_cnt   = 0;
  int waiting   = 0;

  assign mismatches  = bad_cnt;
  assign outstanding = waiting;
  assign n_done      = done_cnt;
  assign n_short     = short_cnt;
  assign n_outside   = out_cnt;

  // scale one coordinate to a bin index, false when outside [0, limit)
  function automatic logic axis_bin(input logic [COORD_W-1:0] coord,
                                    input logic [COORD_W-1:0] origin,
                                    input logic [SCALE_W-1:0] scale,
                                    input int limit, output int bin);
    logic signed [COORD_W:0] diff;
    logic [63:0]             prod;
    logic [63:0]             q;
    diff = $signed({coord[COORD_W-1], coord}) - $signed({origin[COORD_W-1], origin});
    bin  = 0;
    if (diff < 0) return 1'b0;
    prod = {31'b0, diff} * {32'b0, scale};
    q    = prod >> 44;
    if (q >= 64'(limit)) return 1'b0;
    bin = int'(q);
    return 1'b1;
  endfunction

  // saturating increment of one counter
  function automatic void bump(input logic [1:0] color, input int addr);
    if (hist[color][addr] != '1) hist[color][addr] = hist[color][addr] + 1'b1;
  endfunction

  // result of one input beat, applying a deposit to the stores
  function automatic result_t bin_outcome(input logic op, input logic [IN_DATA_W-1:0] beat);
    result_t          r;
    logic [LEN_W-1:0] len;
    logic [1:0]       color;
    int               col;
    int               row;
    int               addr;
    int               base;
    logic             in_re;
    logic             in_im;
    r   = '0;
    len = beat[LEN_LSB +: LEN_W];
    if (op == OP_READ) begin
      addr = int'(beat[RBIN_LSB +: RBIN_W]);
      if (addr >= NBINS) begin
        r.status = ST_OUTSIDE;
      end else begin
        r.red   = hist[COLOR_RED][addr];
        r.green = hist[COLOR_GREEN][addr];
        r.blue  = hist[COLOR_BLUE][addr];
      end
      return r;
    end
    // length test wins over the window test
    if (len < window.ignore_below) begin
      r.status = ST_SHORT;
      return r;
    end
    if (len < window.blue_below) color = COLOR_BLUE;
    else if (len < window.green_below) color = COLOR_GREEN;
    else color = COLOR_RED;
    in_re = axis_bin(beat[RE_LSB +: COORD_W], window.re_origin, window.re_scale, COLUMNS, col);
    in_im = axis_bin(beat[IM_LSB +: COORD_W], window.im_origin, window.im_scale, ROWS, row);
    if (!in_re || !in_im) begin
      r.status = ST_OUTSIDE;
      return r;
    end
    // reversed address, bin and its row mirror
    base = NBINS - 1 - col * ROWS;
    bump(color, base - row);
    bump(color, base - (ROWS - 1 - row));
    return r;
  endfunction

  task automatic flag(input string what, input result_t want, input result_t got);
    bad_cnt++;
    if (bad_cnt <= 10) begin
      $display("%0t %s: expected status %0d red %0d green %0d blue %0d", $realtime, what,
               want.status, want.red, want.green, want.blue);
      $display("%0t %s:      got status %0d red %0d green %0d blue %0d", $realtime, what,
               got.status, got.red, got.green, got.blue);
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      window.re_origin    = RST_ORIGIN;
      window.im_origin    = RST_ORIGIN;
      window.re_scale     = RST_SCALE;
      window.im_scale     = RST_SCALE;
      window.ignore_below = RST_IGNORE;
      window.blue_below   = RST_BLUE;
      window.green_below  = RST_GREEN;
      expected_counts.delete();
    end else begin
      // output beat against the oldest outstanding result
      if (m_tvalid && m_tready) begin
        got.status = m_tdata[0 +: STAT_W];
        got.red    = m_tdata[RED_LSB +: CNT_W];
        got.green  = m_tdata[GREEN_LSB +: CNT_W];
        got.blue   = m_tdata[BLUE_LSB +: CNT_W];
        case (got.status)
          ST_DONE:    done_cnt++;
          ST_SHORT:   short_cnt++;
          ST_OUTSIDE: out_cnt++;
          default:    ;
        endcase
        if (expected_counts.size() == 0) begin
          flag("result beat with no item outstanding", '0, got);
        end else begin
          want = expected_counts.pop_front();
          if (want !== got) flag("result mismatch", want, got);
        end
      end
      // input beat, predicted with the settings held before this edge
      if (s_tvalid && s_tready) begin
        want            = bin_outcome(s_tuser, s_tdata);
        expected_counts = {expected_counts, want};
      end
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_RE_ORIGIN:    window.re_origin    = cfg_wdata;
          REG_IM_ORIGIN:    window.im_origin    = cfg_wdata;
          REG_RE_SCALE:     window.re_scale     = cfg_wdata;
          REG_IM_SCALE:     window.im_scale     = cfg_wdata;
          REG_IGNORE_BELOW: window.ignore_below = cfg_wdata[LEN_W-1:0];
          REG_BLUE_BELOW:   window.blue_below   = cfg_wdata[LEN_W-1:0];
          REG_GREEN_BELOW:  window.green_below  = cfg_wdata[LEN_W-1:0];
          default:          ;
        endcase
      end
    end
    waiting = expected_counts.size();
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench of the orbit density histogram unit
// Drives directed deposits and reads at the window edges and length class
// boundaries, then random traffic under six register settings including
// the extremes, with random idling on both streams, a long receiver
// hold-off and a sender pause. The checker instance judges every result.
// ----------------------------------------------------------------------------
module tb_top;
  import odh_pkg::*;

  typedef longint unsigned u64_t;

  localparam int LIMIT_CYCLES = 600000;
  localparam int PHASE_ITEMS  = 145;
  localparam int HOLD_CYCLES  = 300;

  // window edges at the reset settings
  localparam logic [COORD_W-1:0] TOP_IN  = 32'h1FFF_FFFF;
  localparam logic [COORD_W-1:0] TOP_OUT = 32'h2000_0000;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // point_re, point_im, orbit_length, read_bin
  logic                  s_tuser;   // op
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // status, red_count, green_count, blue_count
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [31:0]           cfg_wdata;

  int mismatches;
  int outstanding;
  int n_done;
  int n_short;
  int n_outside;

  // settings as last written, used to aim the stimulus
  logic [COORD_W-1:0] re_org;
  logic [COORD_W-1:0] im_org;
  logic [SCALE_W-1:0] re_sc;
  logic [SCALE_W-1:0] im_sc;
  logic [LEN_W-1:0]   ign;
  logic [LEN_W-1:0]   blu;
  logic [LEN_W-1:0]   grn;

  int cycles    = 0;
  int hold_left = 0;
  int n_dep     = 0;
  int n_read    = 0;
  bit steady    = 1'b0;
  bit hold_req  = 1'b0;
  int hot_bins [$];

  orbit_density_histogram_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  histogram_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .n_done      (n_done),
    .n_short     (n_short),
    .n_outside   (n_outside)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // result receiver: random stalls, no stalls while steady, one long hold-off
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= steady || ($urandom_range(0, 99) >= 21);
      end
    end
  end

  // one input beat; valid stays high on return so beats can run back to back
  task automatic send_item(input logic op, input logic [COORD_W-1:0] re,
                           input logic [COORD_W-1:0] im, input logic [LEN_W-1:0] len,
                           input logic [RBIN_W-1:0] rbin);
    while (!steady && $urandom_range(0, 99) < 21) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {rbin, len, im, re};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    if (op == OP_READ) n_read++;
    else n_dep++;
  endtask

  task automatic wait_empty();
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  // all results in, then let the pipeline settle
  task automatic drain();
    wait_empty();
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
  endtask

  task automatic apply_config();
    write_reg(REG_RE_ORIGIN, re_org);
    write_reg(REG_IM_ORIGIN, im_org);
    write_reg(REG_RE_SCALE, re_sc);
    write_reg(REG_IM_SCALE, im_sc);
    write_reg(REG_IGNORE_BELOW, 32'(ign));
    write_reg(REG_BLUE_BELOW, 32'(blu));
    write_reg(REG_GREEN_BELOW, 32'(grn));
    cfg_we <= 1'b0;
  endtask

  // coordinate that lands near a given bin index; index -1 falls below the origin
  function automatic logic [COORD_W-1:0] aim(input logic [COORD_W-1:0] origin,
                                             input logic [SCALE_W-1:0] scale, input int bin_idx);
    u64_t   frac;
    u64_t   span;
    longint pos;
    if (bin_idx < 0) begin
      pos = longint'($signed(origin)) - longint'($urandom_range(1, 1 << 16));
    end else if (scale == 0) begin
      pos = longint'($signed(origin)) + longint'($urandom_range(0, 1 << 16));
    end else begin
      frac = (u64_t'($urandom_range(0, 4095)) << 32) | u64_t'($urandom);
      span = ((u64_t'(bin_idx) << 44) + frac) / u64_t'(scale);
      pos  = longint'($signed(origin)) + longint'(span);
    end
    if (pos > 64'sd2147483647) pos = 64'sd2147483647;
    if (pos < -64'sd2147483648) pos = -64'sd2147483648;
    return pos[COORD_W-1:0];
  endfunction

  // lengths cluster around the class thresholds
  function automatic logic [LEN_W-1:0] pick_len();
    int t;
    case ($urandom_range(0, 5))
      0:       t = int'(ign);
      1:       t = int'(blu);
      2:       t = int'(grn);
      3:       return LEN_W'($urandom);
      4:       return $urandom_range(0, 1) ? '1 : '0;
      default: t = int'($urandom_range(0, 2000));
    endcase
    t = t + int'($urandom_range(0, 2)) - 1;
    if (t < 0) t = 0;
    if (t > 65535) t = 65535;
    return LEN_W'(t);
  endfunction

  // mostly aimed deposits, reads of recently hit bins, some noise
  task automatic random_item();
    int                 kind;
    int                 col;
    int                 row;
    logic [COORD_W-1:0] re;
    logic [COORD_W-1:0] im;
    kind = int'($urandom_range(0, 99));
    if (kind < 25) begin
      if (hot_bins.size() > 0 && $urandom_range(0, 9) < 7)
        send_item(OP_READ, $urandom, $urandom, LEN_W'($urandom),
                  RBIN_W'(hot_bins[$urandom_range(0, hot_bins.size() - 1)]));
      else
        send_item(OP_READ, $urandom, $urandom, LEN_W'($urandom), RBIN_W'($urandom));
    end else if (kind < 35) begin
      send_item(OP_DEPOSIT, $urandom, $urandom, LEN_W'($urandom), RBIN_W'($urandom));
    end else begin
      col = int'($urandom_range(0, COLUMNS + 1)) - 1;
      row = int'($urandom_range(0, ROWS + 1)) - 1;
      re  = aim(re_org, re_sc, col);
      im  = aim(im_org, im_sc, row);
      if (col >= 0 && col < COLUMNS && row >= 0 && row < ROWS) begin
        hot_bins = {hot_bins, NBINS - 1 - col * ROWS - row};
        if (hot_bins.size() > 64) void'(hot_bins.pop_front());
      end
      send_item(OP_DEPOSIT, re, im, pick_len(), RBIN_W'($urandom));
    end
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = OP_DEPOSIT;
    cfg_we    = 1'b0;
    cfg_index = REG_RE_ORIGIN;
    cfg_wdata = '0;
    re_org    = RST_ORIGIN;
    im_org    = RST_ORIGIN;
    re_sc     = RST_SCALE;
    im_sc     = RST_SCALE;
    ign       = RST_IGNORE;
    blu       = RST_BLUE;
    grn       = RST_GREEN;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: corners, class boundaries, window edges
    send_item(OP_READ, '0, '0, '0, 16'hFFFF);
    send_item(OP_DEPOSIT, RST_ORIGIN, RST_ORIGIN, 16'd0, '0);
    send_item(OP_DEPOSIT, RST_ORIGIN, RST_ORIGIN, 16'd99, '0);
    send_item(OP_DEPOSIT, RST_ORIGIN, RST_ORIGIN, 16'd100, '0);
    send_item(OP_DEPOSIT, RST_ORIGIN, RST_ORIGIN, 16'd999, '0);
    send_item(OP_DEPOSIT, RST_ORIGIN, RST_ORIGIN, 16'd1000, '0);
    send_item(OP_DEPOSIT, RST_ORIGIN, RST_ORIGIN, 16'hFFFF, '0);
    send_item(OP_READ, '0, '0, '0, 16'hFFFF);
    send_item(OP_READ, '0, '0, '0, 16'hFF00);
    send_item(OP_DEPOSIT, TOP_IN, TOP_IN, 16'd500, '0);
    send_item(OP_READ, '0, '0, '0, 16'h0000);
    // just outside on each side, then the coordinate extremes
    send_item(OP_DEPOSIT, RST_ORIGIN - 1'b1, '0, 16'd500, '0);
    send_item(OP_DEPOSIT, '0, RST_ORIGIN - 1'b1, 16'd500, '0);
    send_item(OP_DEPOSIT, TOP_OUT, '0, 16'd500, '0);
    send_item(OP_DEPOSIT, '0, TOP_OUT, 16'd500, '0);
    send_item(OP_DEPOSIT, 32'h7FFF_FFFF, 32'h8000_0000, 16'd500, '0);
    send_item(OP_DEPOSIT, 32'h8000_0000, 32'h7FFF_FFFF, 16'd500, '0);
    // unused fields carry junk
    send_item(OP_READ, '1, '1, '1, 16'hFFFF);
    send_item(OP_DEPOSIT, '0, '0, 16'd1, 16'hAAAA);
    send_item(OP_READ, 32'h5555_5555, 32'h5555_5555, 16'h5555, 16'h7F7F);
    s_tvalid <= 1'b0;
    drain();

    // too short and threshold length beats, outside and inside of the window
    ign = 16'd50;
    apply_config();
    send_item(OP_DEPOSIT, RST_ORIGIN - 1'b1, '0, 16'd49, '0);
    send_item(OP_DEPOSIT, '0, '0, 16'd49, '0);
    send_item(OP_DEPOSIT, RST_ORIGIN - 1'b1, '0, 16'd50, '0);
    send_item(OP_DEPOSIT, '0, '0, 16'd50, '0);
    send_item(OP_READ, '0, '0, '0, 16'h7F7F);
    s_tvalid <= 1'b0;
    drain();

    // random traffic under six settings
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          re_org = RST_ORIGIN + $urandom_range(0, 1 << 24) - (1 << 23);
          im_org = RST_ORIGIN + $urandom_range(0, 1 << 24) - (1 << 23);
          re_sc  = $urandom_range(32'h0020_0000, 32'h0080_0000);
          im_sc  = $urandom_range(32'h0020_0000, 32'h0080_0000);
          ign    = LEN_W'($urandom_range(0, 20));
          blu    = LEN_W'(ign + $urandom_range(0, 200));
          grn    = LEN_W'(blu + $urandom_range(0, 2000));
        end
        1: begin
          re_org = 32'h8000_0000;
          im_org = 32'h8000_0000;
          re_sc  = 32'hFFFF_FFFF;
          im_sc  = 32'hFFFF_FFFF;
          ign    = '0;
          blu    = '0;
          grn    = '0;
        end
        2: begin
          re_org = 32'h7FFF_FFFF;
          im_org = 32'h7FFF_FFFF;
          re_sc  = '0;
          im_sc  = '0;
          ign    = '1;
          blu    = '1;
          grn    = '1;
        end
        3: begin
          re_org = 32'hC000_0000 + $urandom_range(0, 1 << 24);
          im_org = 32'hC000_0000 + $urandom_range(0, 1 << 24);
          re_sc  = 32'h0001_0000;
          im_sc  = 32'h0002_0000;
          ign    = LEN_W'($urandom_range(0, 10));
          blu    = LEN_W'(ign + $urandom_range(0, 300));
          grn    = LEN_W'(blu + $urandom_range(0, 3000));
        end
        4: begin
          re_org = $urandom;
          im_org = $urandom;
          re_sc  = $urandom;
          im_sc  = $urandom;
          ign    = LEN_W'($urandom);
          blu    = LEN_W'($urandom);
          grn    = LEN_W'($urandom);
        end
        default: begin
          re_org = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
          im_org = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
          re_sc  = 32'hFFFF_FFFF;
          im_sc  = '0;
          ign    = '0;
          blu    = LEN_W'($urandom_range(0, 65535));
          grn    = LEN_W'($urandom_range(blu, 65535));
        end
      endcase
      steady = (p == 0);
      apply_config();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // receiver holds off while beats keep coming
        if (p == 3 && i == 40) hold_req = 1'b1;
        // sender pauses until every result is back
        if (p == 4 && i == 70) begin
          s_tvalid <= 1'b0;
          wait_empty();
        end
        random_item();
      end
      s_tvalid <= 1'b0;
      drain();
    end
    steady = 1'b0;
    repeat (20) @(negedge clk);

    $display("covered %0d deposits and %0d reads over eight register settings", n_dep, n_read);
    $display("results: %0d done, %0d too short, %0d outside window, %0d mismatches",
             n_done, n_short, n_outside, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
